>>> src/e2u8_pkg.sv
// Package for the escape-to-UTF-8 encoder: widths, character codes, beat type, hex decode.
package e2u8_pkg;

   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int MAX_BEATS = 4;
   localparam int SLOT_W    = $clog2(MAX_BEATS);
   localparam int CNT_W     = $clog2(MAX_BEATS + 1);

   // Characters that steer the escape parser
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
   localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

   // UTF-8 range limits
   localparam logic [CP_W-1:0] LIM_1B  = 21'h00007F;
   localparam logic [CP_W-1:0] LIM_2B  = 21'h0007FF;
   localparam logic [CP_W-1:0] LIM_3B  = 21'h00FFFF;
   localparam logic [CP_W-1:0] LIM_4B  = 21'h10FFFF;
   // Largest accumulator value that still takes one more digit
   localparam logic [CP_W-1:0] LIM_ACC = 21'h01FFFF;

   // UTF-8 lead and continuation markers
   localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_B  = 8'h80;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic              byte_valid;
      logic              bad_escape;
   } beat_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_type h;
      h.is_hex = 1'b1;
      h.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

>>> src/escape_to_utf8_encoder.sv
// Escape-to-UTF-8 encoder: byte copy with \u{...} code point escapes turned into UTF-8.
//
//   channel | ports                                             | direction
//   --------+---------------------------------------------------+----------
//   req     | req_valid, req_stall, req_char_in, req_is_final   | in
//   rsp     | rsp_valid, rsp_stall, rsp_byte_out, rsp_byte_valid,| out
//           | rsp_bad_escape, rsp_run_last, rsp_string_end      |
//
// Flow: an input byte lands in the input register, then one pass of parse
// and encode logic moves it into the result buffer. It yields 0 to 4 beats,
// one per cycle while rsp_stall is low; so one input per cycle is sustained
// if each yields at most one beat, and a run holds the input until it drains.
// Reset: synchronous, clears parser phase, escape accumulator and both buffers.
// Stalls: rsp_stall holds the current beat; the input register refills in the
// same cycle the last beat of a run leaves, so req_stall rises only while a
// run is still draining behind a full input register.
module escape_to_utf8_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [e2u8_pkg::BYTE_W-1:0] req_char_in,
   input  logic                       req_is_final,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [e2u8_pkg::BYTE_W-1:0] rsp_byte_out,
   output logic                       rsp_byte_valid,
   output logic                       rsp_bad_escape,
   output logic                       rsp_run_last,
   output logic                       rsp_string_end
);
   import e2u8_pkg::*;

   typedef enum logic [1:0] {
      PH_PLAIN,   // copy bytes through
      PH_BS,      // backslash held
      PH_BSU,     // backslash and 'u' held
      PH_ESC      // inside an escape, collecting digits
   } phase_type;

   // Input register
   logic              in_full_ff;
   logic [BYTE_W-1:0] in_char_ff;
   logic              in_fin_ff;

   // Parser state
   phase_type         phase_ff,   phase_in;
   logic [CP_W-1:0]   accum_ff,   accum_in;
   logic              seen_ff,    seen_in;
   logic              ovf_ff,     ovf_in;
   logic              stopped_ff, stopped_in;

   // Result buffer
   beat_type          slot_ff [MAX_BEATS];
   beat_type          slot_in [MAX_BEATS];
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [SLOT_W-1:0] idx_ff;
   logic              run_fin_ff;

   // Digit step and encoder results
   hex_type           hex;
   logic [CP_W-1:0]   dig_accum;
   logic              dig_seen, dig_ovf, dig_stopped;
   beat_type          enc [MAX_BEATS];
   logic [CNT_W-1:0]  enc_cnt;

   logic              take;
   logic              move;

   // Handshake: the input register hands over when the buffer is empty or
   // its last beat leaves this cycle.
   assign take      = (rem_ff != '0) && !rsp_stall;
   assign move      = in_full_ff &&
                      ((rem_ff == '0) || ((rem_ff == CNT_W'(1)) && !rsp_stall));
   assign req_stall = in_full_ff && !move;

   assign rsp_valid      = (rem_ff != '0);
   assign rsp_byte_out   = slot_ff[idx_ff].byte_out;
   assign rsp_byte_valid = slot_ff[idx_ff].byte_valid;
   assign rsp_bad_escape = slot_ff[idx_ff].bad_escape;
   assign rsp_run_last   = (rem_ff == CNT_W'(1));
   assign rsp_string_end = (rem_ff == CNT_W'(1)) && run_fin_ff;

   // Take one hex digit into the accumulator; the first non-hex byte freezes it.
   // An escape that opens on this byte starts from an empty value.
   always_comb begin
      hex         = hex_decode(in_char_ff);
      dig_accum   = accum_ff;
      dig_seen    = seen_ff;
      dig_ovf     = ovf_ff;
      dig_stopped = stopped_ff;
      if (phase_ff != PH_ESC) begin
         dig_accum   = '0;
         dig_seen    = 1'b0;
         dig_ovf     = 1'b0;
         dig_stopped = 1'b0;
      end else if (in_char_ff != CH_RBRACE) begin
         if (!hex.is_hex) begin
            dig_stopped = 1'b1;
         end else if (!stopped_ff) begin
            dig_seen = 1'b1;
            if (accum_ff > LIM_ACC) begin
               dig_ovf = 1'b1;
            end else begin
               dig_accum = {accum_ff[CP_W-5:0], hex.value};
            end
         end
      end
   end

   // Encode the code point that closes the escape. Out-of-range values
   // yield no beats; a missing or overflowed value yields one error beat.
   always_comb begin
      for (int i = 0; i < MAX_BEATS; i++) begin
         enc[i] = '0;
      end
      enc_cnt = '0;
      if (!dig_seen || dig_ovf) begin
         enc[0].bad_escape = 1'b1;
         enc_cnt           = CNT_W'(1);
      end else if (dig_accum <= LIM_1B) begin
         enc[0]  = '{byte_out: dig_accum[7:0], byte_valid: 1'b1, bad_escape: 1'b0};
         enc_cnt = CNT_W'(1);
      end else if (dig_accum <= LIM_2B) begin
         enc[0]  = '{byte_out: LEAD_2B | {3'b0, dig_accum[10:6]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc[1]  = '{byte_out: CONT_B | {2'b0, dig_accum[5:0]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc_cnt = CNT_W'(2);
      end else if (dig_accum <= LIM_3B) begin
         enc[0]  = '{byte_out: LEAD_3B | {4'b0, dig_accum[15:12]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc[1]  = '{byte_out: CONT_B | {2'b0, dig_accum[11:6]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc[2]  = '{byte_out: CONT_B | {2'b0, dig_accum[5:0]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc_cnt = CNT_W'(3);
      end else if (dig_accum <= LIM_4B) begin
         enc[0]  = '{byte_out: LEAD_4B | {5'b0, dig_accum[20:18]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc[1]  = '{byte_out: CONT_B | {2'b0, dig_accum[17:12]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc[2]  = '{byte_out: CONT_B | {2'b0, dig_accum[11:6]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc[3]  = '{byte_out: CONT_B | {2'b0, dig_accum[5:0]},
                     byte_valid: 1'b1, bad_escape: 1'b0};
         enc_cnt = CNT_W'(4);
      end
   end

   // Parse one byte: build the beat list and the next parser state.
   always_comb begin
      logic close_now;
      close_now  = 1'b0;
      phase_in   = phase_ff;
      accum_in   = accum_ff;
      seen_in    = seen_ff;
      ovf_in     = ovf_ff;
      stopped_in = stopped_ff;
      cnt_in     = '0;
      for (int i = 0; i < MAX_BEATS; i++) begin
         slot_in[i] = '0;
      end

      case (phase_ff)
         PH_BS: begin
            if (in_char_ff == CH_U) begin
               phase_in = PH_BSU;
            end else if (in_char_ff == CH_BSLASH) begin
               // flush the held backslash, hold the new one
               slot_in[0] = '{byte_out: CH_BSLASH, byte_valid: 1'b1, bad_escape: 1'b0};
               cnt_in     = CNT_W'(1);
            end else begin
               slot_in[0] = '{byte_out: CH_BSLASH, byte_valid: 1'b1, bad_escape: 1'b0};
               slot_in[1] = '{byte_out: in_char_ff, byte_valid: 1'b1, bad_escape: 1'b0};
               cnt_in     = CNT_W'(2);
               phase_in   = PH_PLAIN;
            end
         end
         PH_BSU: begin
            if (in_char_ff == CH_LBRACE) begin
               phase_in   = PH_ESC;
               accum_in   = '0;
               seen_in    = 1'b0;
               ovf_in     = 1'b0;
               stopped_in = 1'b0;
            end else begin
               slot_in[0] = '{byte_out: CH_BSLASH, byte_valid: 1'b1, bad_escape: 1'b0};
               slot_in[1] = '{byte_out: CH_U, byte_valid: 1'b1, bad_escape: 1'b0};
               if (in_char_ff == CH_BSLASH) begin
                  cnt_in   = CNT_W'(2);
                  phase_in = PH_BS;
               end else begin
                  slot_in[2] = '{byte_out: in_char_ff, byte_valid: 1'b1, bad_escape: 1'b0};
                  cnt_in     = CNT_W'(3);
                  phase_in   = PH_PLAIN;
               end
            end
         end
         PH_ESC: begin
            if (in_char_ff == CH_RBRACE) begin
               close_now = 1'b1;
               phase_in  = PH_PLAIN;
            end else begin
               accum_in   = dig_accum;
               seen_in    = dig_seen;
               ovf_in     = dig_ovf;
               stopped_in = dig_stopped;
            end
         end
         default: begin
            if (in_char_ff == CH_BSLASH) begin
               phase_in = PH_BS;
            end else begin
               slot_in[0] = '{byte_out: in_char_ff, byte_valid: 1'b1, bad_escape: 1'b0};
               cnt_in     = CNT_W'(1);
            end
         end
      endcase

      // End of string: flush what is held and close an open escape
      if (in_fin_ff) begin
         case (phase_in)
            PH_BS: begin
               slot_in[cnt_in[SLOT_W-1:0]] =
                  '{byte_out: CH_BSLASH, byte_valid: 1'b1, bad_escape: 1'b0};
               cnt_in = cnt_in + CNT_W'(1);
            end
            PH_BSU: begin
               slot_in[cnt_in[SLOT_W-1:0]] =
                  '{byte_out: CH_BSLASH, byte_valid: 1'b1, bad_escape: 1'b0};
               slot_in[cnt_in[SLOT_W-1:0] + SLOT_W'(1)] =
                  '{byte_out: CH_U, byte_valid: 1'b1, bad_escape: 1'b0};
               cnt_in = cnt_in + CNT_W'(2);
            end
            PH_ESC: begin
               close_now = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // An escape always closes with nothing else in the list
      if (close_now) begin
         for (int i = 0; i < MAX_BEATS; i++) begin
            slot_in[i] = enc[i];
         end
         cnt_in = enc_cnt;
      end

      if (in_fin_ff) begin
         phase_in   = PH_PLAIN;
         accum_in   = '0;
         seen_in    = 1'b0;
         ovf_in     = 1'b0;
         stopped_in = 1'b0;
         // carry string_end on an empty beat when the last byte yields nothing
         if (cnt_in == '0) begin
            slot_in[0] = '0;
            cnt_in     = CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff <= 1'b0;
         phase_ff   <= PH_PLAIN;
         accum_ff   <= '0;
         seen_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
         stopped_ff <= 1'b0;
         rem_ff     <= '0;
         idx_ff     <= '0;
         run_fin_ff <= 1'b0;
      end else begin
         // input register: refill on accept, drop when handed over
         if (req_valid && !req_stall) begin
            in_full_ff <= 1'b1;
         end else if (move) begin
            in_full_ff <= 1'b0;
         end

         if (move) begin
            phase_ff   <= phase_in;
            accum_ff   <= accum_in;
            seen_ff    <= seen_in;
            ovf_ff     <= ovf_in;
            stopped_ff <= stopped_in;
            rem_ff     <= cnt_in;
            idx_ff     <= '0;
            run_fin_ff <= in_fin_ff;
         end else if (take) begin
            // advance to the next beat of the run
            rem_ff <= rem_ff - CNT_W'(1);
            idx_ff <= idx_ff + SLOT_W'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_in;
         in_fin_ff  <= req_is_final;
      end
      if (move) begin
         for (int i = 0; i < MAX_BEATS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= CNT_W'(MAX_BEATS))
      else $error("result buffer holds more beats than it has slots");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (take && !move) |=> (idx_ff == $past(idx_ff) + SLOT_W'(1)))
      else $error("beat index did not advance after a beat left");

   a_fin_reset: assert property (@(posedge clock) disable iff (reset)
      (move && in_fin_ff) |=> (phase_ff == PH_PLAIN && !seen_ff && !ovf_ff))
      else $error("parser state not cleared after end of string");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_end) |-> rsp_run_last)
      else $error("string end flagged on a beat that is not last of its run");

   a_bad_novalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_escape) |-> (!rsp_byte_valid && rsp_run_last))
      else $error("error beat carries a byte or is not alone in its run");

endmodule

>>> tb/escape_to_utf8_encoder_tb.sv
// Self-checking testbench for the escape-to-UTF-8 encoder: directed and random strings.
`timescale 1ns / 1ps

module escape_to_utf8_encoder_tb;
   import e2u8_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int HOLD_CYCLES = 120;   // long receiver hold-off, in cycles
   localparam int STUCK_LIMIT = 2000;  // cycles with no beat on either side

   // Parser phases of the encoder, as the predictor tracks them
   typedef enum logic [2:0] {PH_PLAIN, PH_BSL, PH_BSL_U, PH_ESCAPE} scan_phase_type;

   // One result beat as it leaves the block
   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic              byte_valid;
      logic              bad_escape;
      logic              run_last;
      logic              string_end;
   } utf8_beat_type;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_char_in  = '0;
   logic              req_is_final = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   logic [BYTE_W-1:0] rsp_byte_out;
   logic              rsp_byte_valid;
   logic              rsp_bad_escape;
   logic              rsp_run_last;
   logic              rsp_string_end;

   // Predictor state: a private copy of the parser
   scan_phase_type    scan_phase     = PH_PLAIN;
   logic [CP_W-1:0]   cp_accum       = '0;
   logic              cp_has_digit   = 1'b0;
   logic              cp_overflow    = 1'b0;
   logic              cp_digits_done = 1'b0;

   utf8_beat_type     step_beats[$];      // beats caused by the byte being predicted
   utf8_beat_type     pending_utf8_q[$];  // beats still owed by the block
   logic [BYTE_W-1:0] text_bytes[$];      // random string under construction

   int                fail_count    = 0;
   int                items_sent    = 0;
   int                stuck_cycles  = 0;
   bit                send_gap_en   = 1'b0;
   bit                rsp_gap_en    = 1'b0;
   bit                hold_rsp_long = 1'b0;

   escape_to_utf8_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_is_final   (req_is_final),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_bad_escape (rsp_bad_escape),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Value of a hex digit, or -1 for anything else (no signs, no prefixes)
   function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic void push_beat(input logic [BYTE_W-1:0] b, input logic vld,
                                     input logic bad);
      utf8_beat_type beat;
      beat = {b, vld, bad, 1'b0, 1'b0};
      step_beats.insert(step_beats.size(), beat);
   endfunction

   // Close an escape: flag it if empty or overflowed, else emit 1 to 4 UTF-8 bytes.
   // Points past the Unicode range drop silently.
   function automatic void encode_code_point();
      if (!cp_has_digit || cp_overflow) begin
         push_beat('0, 1'b0, 1'b1);
      end else if (cp_accum <= LIM_1B) begin
         push_beat(cp_accum[7:0], 1'b1, 1'b0);
      end else if (cp_accum <= LIM_2B) begin
         push_beat(LEAD_2B | {3'b000, cp_accum[10:6]}, 1'b1, 1'b0);
         push_beat(CONT_B | {2'b00, cp_accum[5:0]}, 1'b1, 1'b0);
      end else if (cp_accum <= LIM_3B) begin
         push_beat(LEAD_3B | {4'h0, cp_accum[15:12]}, 1'b1, 1'b0);
         push_beat(CONT_B | {2'b00, cp_accum[11:6]}, 1'b1, 1'b0);
         push_beat(CONT_B | {2'b00, cp_accum[5:0]}, 1'b1, 1'b0);
      end else if (cp_accum <= LIM_4B) begin
         push_beat(LEAD_4B | {5'b00000, cp_accum[20:18]}, 1'b1, 1'b0);
         push_beat(CONT_B | {2'b00, cp_accum[17:12]}, 1'b1, 1'b0);
         push_beat(CONT_B | {2'b00, cp_accum[11:6]}, 1'b1, 1'b0);
         push_beat(CONT_B | {2'b00, cp_accum[5:0]}, 1'b1, 1'b0);
      end
   endfunction

   // Advance the parser by one accepted byte and queue the beats it owes
   function automatic void predict_utf8(input logic [BYTE_W-1:0] c, input logic fin);
      int d;
      step_beats.delete();
      d = hex_nibble(c);
      case (scan_phase)
         PH_BSL: begin
            if (c == CH_U) begin
               scan_phase = PH_BSL_U;
            end else if (c == CH_BSLASH) begin
               push_beat(CH_BSLASH, 1'b1, 1'b0);
            end else begin
               push_beat(CH_BSLASH, 1'b1, 1'b0);
               push_beat(c, 1'b1, 1'b0);
               scan_phase = PH_PLAIN;
            end
         end
         PH_BSL_U: begin
            if (c == CH_LBRACE) begin
               scan_phase     = PH_ESCAPE;
               cp_accum       = '0;
               cp_has_digit   = 1'b0;
               cp_overflow    = 1'b0;
               cp_digits_done = 1'b0;
            end else begin
               push_beat(CH_BSLASH, 1'b1, 1'b0);
               push_beat(CH_U, 1'b1, 1'b0);
               if (c == CH_BSLASH) begin
                  scan_phase = PH_BSL;
               end else begin
                  push_beat(c, 1'b1, 1'b0);
                  scan_phase = PH_PLAIN;
               end
            end
         end
         PH_ESCAPE: begin
            if (c == CH_RBRACE) begin
               encode_code_point();
               scan_phase = PH_PLAIN;
            end else if (d < 0) begin
               cp_digits_done = 1'b1;
            end else if (!cp_digits_done) begin
               cp_has_digit = 1'b1;
               if (cp_accum > LIM_ACC) cp_overflow = 1'b1;
               else cp_accum = {cp_accum[CP_W-5:0], d[3:0]};
            end
         end
         default: begin
            if (c == CH_BSLASH) scan_phase = PH_BSL;
            else push_beat(c, 1'b1, 1'b0);
         end
      endcase

      // End of string: flush held bytes, close an open escape, back to reset state
      if (fin) begin
         case (scan_phase)
            PH_BSL: push_beat(CH_BSLASH, 1'b1, 1'b0);
            PH_BSL_U: begin
               push_beat(CH_BSLASH, 1'b1, 1'b0);
               push_beat(CH_U, 1'b1, 1'b0);
            end
            PH_ESCAPE: encode_code_point();
            default: ;
         endcase
         scan_phase     = PH_PLAIN;
         cp_accum       = '0;
         cp_has_digit   = 1'b0;
         cp_overflow    = 1'b0;
         cp_digits_done = 1'b0;
         // A final byte always carries at least an empty marker beat
         if (step_beats.size() == 0) push_beat('0, 1'b0, 1'b0);
         step_beats[step_beats.size() - 1].string_end = 1'b1;
      end
      if (step_beats.size() != 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
      foreach (step_beats[i]) pending_utf8_q.insert(pending_utf8_q.size(), step_beats[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one byte from a falling edge; return at the falling edge after it is taken.
   // Valid stays high on return so back-to-back bytes need no extra assignment.
   task automatic send_char(input logic [BYTE_W-1:0] c, input logic fin);
      if (send_gap_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_char_in  <= c;
      req_is_final <= fin;
      do @(posedge clock); while (req_stall);
      predict_utf8(c, fin);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++) send_char(s[i], fin && (i == s.len() - 1));
   endtask

   task automatic wait_for_drain();
      while (pending_utf8_q.size() != 0) @(negedge clock);
   endtask

   // Drop valid and hold the input until every owed beat has come out
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      wait_for_drain();
   endtask

   // Append one byte to the string under construction
   function automatic void add_text_byte(input logic [BYTE_W-1:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   // Append hex digits of val, most significant first, in random letter case
   task automatic add_hex_digits(input logic [31:0] val, input int ndig);
      logic [3:0] nib;
      for (int i = ndig - 1; i >= 0; i--) begin
         nib = val[4 * i +: 4];
         if (nib < 10) add_text_byte(8'h30 + {4'h0, nib});
         else if ($urandom_range(0, 1)) add_text_byte(8'h61 + {4'h0, nib} - 8'd10);
         else add_text_byte(8'h41 + {4'h0, nib} - 8'd10);
      end
   endtask

   // Append a well-formed escape; pick the size class first so every UTF-8
   // length, the out-of-range band, overflow and the empty escape all show up
   task automatic add_escape(input bit last);
      logic [31:0]       cp;
      logic [BYTE_W-1:0] junk;
      int                ndig;
      int                kind;
      add_text_byte(CH_BSLASH);
      add_text_byte(CH_U);
      add_text_byte(CH_LBRACE);
      kind = $urandom_range(0, 6);
      case (kind)
         0:       cp = $urandom_range(0, 32'h7F);
         1:       cp = $urandom_range(32'h80, 32'h7FF);
         2:       cp = $urandom_range(32'h800, 32'hFFFF);
         3:       cp = $urandom_range(32'h10000, 32'h10FFFF);
         4:       cp = $urandom_range(32'h110000, 32'h1FFFFF);
         5:       cp = $urandom_range(32'h200000, 32'hFFFFFFFF);
         default: cp = '0;
      endcase
      if (kind == 6) begin
         ndig = 0;
      end else if (kind == 5) begin
         ndig = 8;
      end else begin
         ndig = 1;
         while (ndig < 8 && (cp >> (4 * ndig)) != 0) ndig++;
         // leading zeros must not count toward overflow
         if ($urandom_range(0, 3) == 0) ndig++;
      end
      add_hex_digits(cp, ndig);
      // A stray non-hex byte ends digit collection; digits after it are dropped
      if ($urandom_range(0, 5) == 0) begin
         do junk = BYTE_W'($urandom_range(0, 255));
         while (hex_nibble(junk) >= 0 || junk == CH_RBRACE);
         add_text_byte(junk);
         add_hex_digits($urandom, $urandom_range(0, 2));
      end
      // Sometimes leave the escape open so the string end has to close it
      if (!(last && $urandom_range(0, 3) == 0)) add_text_byte(CH_RBRACE);
   endtask

   // One string of plain bytes, escapes and broken escape openers, final flag on its last byte
   task automatic send_random_string();
      int nseg;
      int kind;
      text_bytes.delete();
      nseg = $urandom_range(1, 8);
      for (int s = 0; s < nseg; s++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            add_text_byte(BYTE_W'($urandom_range(0, 255)));
         end else if (kind < 9) begin
            add_escape(s == nseg - 1);
         end else begin
            add_text_byte(CH_BSLASH);
            if ($urandom_range(0, 1)) add_text_byte(CH_U);
            // at string end the opener may be left dangling
            if (s != nseg - 1 || $urandom_range(0, 1))
               add_text_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end
      foreach (text_bytes[i]) send_char(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Byte extremes, and a string ending on a byte that is copied through
   task automatic test_directed_extremes();
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
   endtask

   task automatic test_directed_escapes();
      send_text("\\u{}", 1'b1);         // no digits: error beat
      send_text("\\u{+}", 1'b1);        // sign is not a digit: error beat
      send_text("\\\\u\\", 1'b1);       // double backslash, backslash-u flushed, lone one at end
      send_text("\\u{10FFFF", 1'b1);    // top code point, escape closed by string end
   endtask

   // Stop the receiver for a long stretch while multi-byte escapes keep coming,
   // so the block fills up and has to stall its input
   task automatic test_receiver_holdoff();
      hold_rsp_long = 1'b1;
      send_text("\\u{10FFFF}\\u{E9}\\u{20AC}xyz\\u{1F600}", 1'b1);
      pause_until_drained();
   endtask

   // Pause in the middle of an escape until the block is empty, then finish it
   task automatic test_drain_pause();
      send_text("ab\\u{3b", 1'b0);
      pause_until_drained();
      send_text("1}", 1'b1);
      pause_until_drained();
   endtask

   task automatic test_random_strings(input int n_items);
      int start;
      start = items_sent;
      while (items_sent - start < n_items) send_random_string();
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Receiver pacing: a long hold-off on request, otherwise random stall bursts
   initial begin : rsp_pacer
      forever begin
         @(negedge clock);
         if (hold_rsp_long) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall     <= 1'b0;
            hold_rsp_long  = 1'b0;
         end else if (rsp_gap_en && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every accepted beat with the oldest owed one
   always @(posedge clock) begin : beat_check
      utf8_beat_type got;
      utf8_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_byte_out, rsp_byte_valid, rsp_bad_escape, rsp_run_last, rsp_string_end};
         if (pending_utf8_q.size() == 0) begin
            $display("%0t: beat with none owed: byte_out=%02h byte_valid=%b bad_escape=%b %s%b %s%b",
                     $time, got.byte_out, got.byte_valid, got.bad_escape,
                     "run_last=", got.run_last, "string_end=", got.string_end);
            fail_count++;
         end else begin
            want = pending_utf8_q.pop_front();
            if (got.byte_out !== want.byte_out || got.byte_valid !== want.byte_valid ||
                got.bad_escape !== want.bad_escape || got.run_last !== want.run_last ||
                got.string_end !== want.string_end) begin
               $display("%0t: mismatch expected %02h/%b/%b/%b/%b actual %02h/%b/%b/%b/%b %s",
                        $time, want.byte_out, want.byte_valid, want.bad_escape, want.run_last,
                        want.string_end, got.byte_out, got.byte_valid, got.bad_escape,
                        got.run_last, got.string_end,
                        "(byte_out/byte_valid/bad_escape/run_last/string_end)");
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run if neither side moves a beat for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_directed_escapes();
      test_receiver_holdoff();
      test_drain_pause();

      // bulk of the random strings with idle bursts on both sides
      send_gap_en = 1'b1;
      rsp_gap_en  = 1'b1;
      test_random_strings(280);

      // last stretch at full rate
      send_gap_en = 1'b0;
      rsp_gap_en  = 1'b0;
      test_random_strings(50);

      req_valid <= 1'b0;
      @(negedge clock);
      wait_for_drain();
      // let any stray late beat show up
      repeat (20) @(negedge clock);

      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
